/* src/tsia_pkg.sv */
// ----------------------------------------------------------------------------
// tsia_pkg: shared types and constants for the tagged small-integer ALU
// Word layout, operation and kind codes, and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsia_pkg;

  localparam int WORD_W = 64;
  localparam int TAG_W  = 3;
  localparam int PAY_W  = WORD_W - TAG_W;   // 61-bit payload

  // Largest magnitudes of a small integer: 2^60 - 1 positive, 2^60 negative.
  localparam logic [PAY_W-1:0] PAY_SIGN = PAY_W'(1) << (PAY_W - 1);
  localparam logic [PAY_W-1:0] POS_MAX  = PAY_SIGN - PAY_W'(1);

  // Unicode scalar limits
  localparam logic [PAY_W-1:0] CHAR_MAX       = PAY_W'(32'h0010_ffff);
  localparam logic [PAY_W-1:0] SURROGATE_LO   = PAY_W'(32'h0000_d800);
  localparam logic [PAY_W-1:0] SURROGATE_HI   = PAY_W'(32'h0000_dfff);

  // Special value payloads
  localparam logic [PAY_W-1:0] PAY_NIL   = PAY_W'(0);
  localparam logic [PAY_W-1:0] PAY_FALSE = PAY_W'(1);
  localparam logic [PAY_W-1:0] PAY_TRUE  = PAY_W'(2);

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_SUB      = 3'd1,
    MODE_MUL      = 3'd2,
    MODE_NEG      = 3'd3,
    MODE_CLASSIFY = 3'd4,
    MODE_BOX      = 3'd5,
    MODE_UNBOX    = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_OBJECT  = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_CHAR    = 3'd3,
    KIND_NIL     = 3'd4,
    KIND_FALSE   = 3'd5,
    KIND_TRUE    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CFG_INT_TAG     = 2'd0,
    CFG_CHAR_TAG    = 2'd1,
    CFG_SPECIAL_TAG = 2'd2
  } cfg_idx_t;

  localparam logic [TAG_W-1:0] INT_TAG_RST     = TAG_W'(1);
  localparam logic [TAG_W-1:0] CHAR_TAG_RST    = TAG_W'(2);
  localparam logic [TAG_W-1:0] SPECIAL_TAG_RST = TAG_W'(3);

endpackage

`default_nettype wire

/* src/tagged_small_integer_alu.sv */
// ----------------------------------------------------------------------------
// tagged_small_integer_alu: checked arithmetic on 64-bit tagged values
// Classifies the first operand and runs add, subtract, multiply, negate,
// classify, box or unbox on 61-bit small integers held under a tag.
// ----------------------------------------------------------------------------
// Users: a request enters on the s_ side and its result leaves on the m_ side
// after passing all stages; one request can enter every cycle and the pipe keeps
// flowing as long as the m_ side takes results. The pipe has the five
// register stages of the 61x61 magnitude multiply: operand decode, four
// partial products (32x32 and smaller), cross-term sum, product assembly,
// and the final range check with sign fix-up. Add, subtract, negate, classify,
// box and unbox finish early and ride along. Each stage has its own valid bit
// and holds when the one after it is full and stalled, so bubbles are squeezed
// out and the input keeps taking requests while a result waits. The three
// tag registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no request is in flight. Failed operations (non-integer
// operand, overflow) return result 0 with ok 0; kind always reports lhs.
`default_nettype none

module tagged_small_integer_alu (
  input  wire logic          clk,
  input  wire logic          rst,
  // request: mode[2:0], lhs[66:3], rhs[130:67], zero pad [135:131]
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [135:0]  s_tdata,
  // result: result[63:0], ok[64], kind[67:65], zero pad [71:68]
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata,
  // tag registers
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [tsia_pkg::TAG_W-1:0] cfg_data
);

  import tsia_pkg::*;

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  typedef struct packed {
    mode_t              mode;
    kind_t              kind;
    logic               lhs_int;
    logic               both_int;
    logic [PAY_W-1:0]   a;        // two's complement payloads
    logic [PAY_W-1:0]   b;
    logic [PAY_W-1:0]   ma;       // magnitudes for the multiplier
    logic [PAY_W-1:0]   mb;
    logic               neg;      // product sign
    logic [WORD_W-1:0]  lhs;
  } s1_t;

  typedef struct packed {
    mode_t              mode;
    kind_t              kind;
    logic               both_int;
    logic               neg;
    logic [WORD_W-1:0]  alt_res;  // result of everything but multiply
    logic               alt_ok;
    logic [63:0]        pll;      // lo x lo
    logic [60:0]        plh;      // lo x hi
    logic [60:0]        phl;      // hi x lo
    logic [57:0]        phh;      // hi x hi
  } s2_t;

  typedef struct packed {
    mode_t              mode;
    kind_t              kind;
    logic               both_int;
    logic               neg;
    logic [WORD_W-1:0]  alt_res;
    logic               alt_ok;
    logic [63:0]        pll;
    logic [61:0]        mid;
    logic               hh_nz;
  } s3_t;

  typedef struct packed {
    mode_t              mode;
    kind_t              kind;
    logic               both_int;
    logic               neg;
    logic [WORD_W-1:0]  alt_res;
    logic               alt_ok;
    logic               big;      // product at least 2^61
    logic [PAY_W-1:0]   plow;     // product bits [60:0]
  } s4_t;

  // --------------------------------------------------------------------------
  // Tag registers
  // --------------------------------------------------------------------------
  logic [TAG_W-1:0] int_tag;
  logic [TAG_W-1:0] char_tag;
  logic [TAG_W-1:0] special_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_tag     <= INT_TAG_RST;
      char_tag    <= CHAR_TAG_RST;
      special_tag <= SPECIAL_TAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INT_TAG:     int_tag     <= cfg_data;
        CFG_CHAR_TAG:    char_tag    <= cfg_data;
        CFG_SPECIAL_TAG: special_tag <= cfg_data;
        default: ;       // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // First matching tag wins: object, int, char, special.
  function automatic kind_t classify_word(input logic [WORD_W-1:0] v,
                                          input logic [TAG_W-1:0]  it,
                                          input logic [TAG_W-1:0]  ct,
                                          input logic [TAG_W-1:0]  st);
    logic [TAG_W-1:0] tag;
    logic [PAY_W-1:0] pay;
    kind_t            k;
    tag = v[TAG_W-1:0];
    pay = v[WORD_W-1:TAG_W];
    k   = KIND_INVALID;
    if (tag == '0) begin
      k = (v == '0) ? KIND_INVALID : KIND_OBJECT;
    end else if (tag == it) begin
      k = KIND_INTEGER;
    end else if (tag == ct) begin
      if (pay <= CHAR_MAX && !(pay >= SURROGATE_LO && pay <= SURROGATE_HI)) begin
        k = KIND_CHAR;
      end
    end else if (tag == st) begin
      if (pay == PAY_NIL) begin
        k = KIND_NIL;
      end else if (pay == PAY_FALSE) begin
        k = KIND_FALSE;
      end else if (pay == PAY_TRUE) begin
        k = KIND_TRUE;
      end
    end
    return k;
  endfunction

  // 62-bit sum fits the 61-bit range when its top two bits agree
  function automatic logic fits62(input logic [PAY_W:0] r);
    return r[PAY_W] == r[PAY_W-1];
  endfunction

  // --------------------------------------------------------------------------
  // Stage handshake: each stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !m_tvalid || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1       <= s_tvalid;
      if (en2) v2       <= v1;
      if (en3) v3       <= v2;
      if (en4) v4       <= v3;
      if (en5) m_tvalid <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode operands, take magnitudes
  // --------------------------------------------------------------------------
  s1_t               s1, s1_next;
  logic [WORD_W-1:0] in_lhs, in_rhs;
  kind_t             rhs_kind;

  assign in_lhs = s_tdata[66:3];
  assign in_rhs = s_tdata[130:67];

  always_comb begin
    s1_next.mode     = mode_t'(s_tdata[2:0]);
    s1_next.kind     = classify_word(in_lhs, int_tag, char_tag, special_tag);
    rhs_kind         = classify_word(in_rhs, int_tag, char_tag, special_tag);
    s1_next.lhs_int  = s1_next.kind == KIND_INTEGER;
    s1_next.both_int = s1_next.lhs_int && rhs_kind == KIND_INTEGER;
    s1_next.a        = in_lhs[WORD_W-1:TAG_W];
    s1_next.b        = in_rhs[WORD_W-1:TAG_W];
    s1_next.ma       = s1_next.a[PAY_W-1] ? (PAY_W'(0) - s1_next.a) : s1_next.a;
    s1_next.mb       = s1_next.b[PAY_W-1] ? (PAY_W'(0) - s1_next.b) : s1_next.b;
    s1_next.neg      = s1_next.a[PAY_W-1] ^ s1_next.b[PAY_W-1];
    s1_next.lhs      = in_lhs;
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
  end

  // --------------------------------------------------------------------------
  // Stage 2: add/sub/negate/classify/box/unbox, four partial products
  // --------------------------------------------------------------------------
  s2_t              s2, s2_next;
  logic [PAY_W:0]   a_ext, b_ext, r_add, r_sub, r_neg;

  always_comb begin
    a_ext = {s1.a[PAY_W-1], s1.a};
    b_ext = {s1.b[PAY_W-1], s1.b};
    r_add = a_ext + b_ext;
    r_sub = a_ext - b_ext;
    r_neg = (PAY_W+1)'(0) - a_ext;

    s2_next.mode     = s1.mode;
    s2_next.kind     = s1.kind;
    s2_next.both_int = s1.both_int;
    s2_next.neg      = s1.neg;
    s2_next.alt_res  = '0;
    s2_next.alt_ok   = 1'b0;

    case (s1.mode)
      MODE_ADD: begin
        s2_next.alt_ok  = s1.both_int && fits62(r_add);
        s2_next.alt_res = {r_add[PAY_W-1:0], int_tag};
      end
      MODE_SUB: begin
        s2_next.alt_ok  = s1.both_int && fits62(r_sub);
        s2_next.alt_res = {r_sub[PAY_W-1:0], int_tag};
      end
      MODE_NEG: begin
        s2_next.alt_ok  = s1.lhs_int && fits62(r_neg);
        s2_next.alt_res = {r_neg[PAY_W-1:0], int_tag};
      end
      MODE_CLASSIFY: begin
        s2_next.alt_ok  = s1.kind != KIND_INVALID;
      end
      MODE_BOX: begin
        // raw int64 fits when bits [63:60] are all sign copies
        s2_next.alt_ok  = (s1.lhs[63:60] == 4'h0) || (s1.lhs[63:60] == 4'hf);
        s2_next.alt_res = {s1.lhs[PAY_W-1:0], int_tag};
      end
      MODE_UNBOX: begin
        s2_next.alt_ok  = s1.lhs_int;
        s2_next.alt_res = {{TAG_W{s1.a[PAY_W-1]}}, s1.a};
      end
      default: ;   // multiply is finished in the last stage; nop fails
    endcase
    if (!s2_next.alt_ok) s2_next.alt_res = '0;

    s2_next.pll = 64'(s1.ma[31:0])  * 64'(s1.mb[31:0]);
    s2_next.plh = 61'(s1.ma[31:0])  * 61'(s1.mb[60:32]);
    s2_next.phl = 61'(s1.ma[60:32]) * 61'(s1.mb[31:0]);
    s2_next.phh = 58'(s1.ma[60:32]) * 58'(s1.mb[60:32]);
  end

  always_ff @(posedge clk) begin
    if (en2) s2 <= s2_next;
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum cross terms; any hi x hi bit means overflow
  // --------------------------------------------------------------------------
  s3_t s3, s3_next;

  always_comb begin
    s3_next.mode     = s2.mode;
    s3_next.kind     = s2.kind;
    s3_next.both_int = s2.both_int;
    s3_next.neg      = s2.neg;
    s3_next.alt_res  = s2.alt_res;
    s3_next.alt_ok   = s2.alt_ok;
    s3_next.pll      = s2.pll;
    s3_next.mid      = 62'(s2.plh) + 62'(s2.phl);
    s3_next.hh_nz    = |s2.phh;
  end

  always_ff @(posedge clk) begin
    if (en3) s3 <= s3_next;
  end

  // --------------------------------------------------------------------------
  // Stage 4: assemble the low 95 bits of the product
  // --------------------------------------------------------------------------
  s4_t         s4, s4_next;
  logic [94:0] psum;

  always_comb begin
    psum             = 95'(s3.pll) + 95'({s3.mid, 32'd0});
    s4_next.mode     = s3.mode;
    s4_next.kind     = s3.kind;
    s4_next.both_int = s3.both_int;
    s4_next.neg      = s3.neg;
    s4_next.alt_res  = s3.alt_res;
    s4_next.alt_ok   = s3.alt_ok;
    s4_next.big      = s3.hh_nz || (|psum[94:PAY_W]);
    s4_next.plow     = psum[PAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en4) s4 <= s4_next;
  end

  // --------------------------------------------------------------------------
  // Stage 5: product range check and sign, output register
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] out_res, out_res_next;
  logic              out_ok, out_ok_next;
  kind_t             out_kind;
  logic [PAY_W-1:0]  lim, pmag;
  logic              mul_ok;

  always_comb begin
    lim    = s4.neg ? PAY_SIGN : POS_MAX;
    mul_ok = s4.both_int && !s4.big && (s4.plow <= lim);
    pmag   = s4.neg ? (PAY_W'(0) - s4.plow) : s4.plow;
    if (s4.mode == MODE_MUL) begin
      out_ok_next  = mul_ok;
      out_res_next = mul_ok ? {pmag, int_tag} : '0;
    end else begin
      out_ok_next  = s4.alt_ok;
      out_res_next = s4.alt_res;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_res  <= out_res_next;
      out_ok   <= out_ok_next;
      out_kind <= s4.kind;
    end
  end

  assign m_tdata = {4'd0, out_kind, out_ok, out_res};

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tagged_small_integer_alu
// Directed requests (extremes, every mode, tag and payload corner cases) and
// then random requests under several tag settings and handshake patterns.
// Each result is checked against a fixed expectation or an in-bench model of the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tsia_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 20;       // pipe is five deep, leave margin
  localparam int PHASE_REQS   = 100;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;  // no register here

  // result word as it leaves on m_tdata[67:0]: value, ok, kind (low to high)
  typedef struct packed {
    kind_t       kind;
    logic        ok;
    logic [63:0] value;
  } alu_out_t;

  // directed request; want_* only meaningful when fixed is set
  typedef struct {
    mode_t       op;
    logic [63:0] lhs;
    logic [63:0] rhs;
    bit          fixed;
    logic [63:0] want_value;
    logic        want_ok;
    kind_t       want_kind;
  } dir_row_t;

  // one random phase: tag setting plus handshake pattern
  typedef struct {
    logic [2:0] int_tag;
    logic [2:0] char_tag;
    logic [2:0] special_tag;
    int         idle;
    int         stall;
    int         hold;
  } phase_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;   // mode[2:0], lhs[66:3], rhs[130:67], pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;        // value[63:0], ok[64], kind[67:65], pad
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [TAG_W-1:0] cfg_data = '0;

  // tag settings as the block should hold them
  logic [2:0] int_tag_q     = INT_TAG_RST;
  logic [2:0] char_tag_q    = CHAR_TAG_RST;
  logic [2:0] special_tag_q = SPECIAL_TAG_RST;

  alu_out_t pending_results[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;       // sender gap odds, percent
  int       stall_pct = 0;      // receiver stall odds, percent
  int       hold_req = 0;       // long receiver hold-off, picked up below
  int       hold_left = 0;

  dir_row_t dir_rows [26] = '{
    // checked arithmetic
    '{MODE_ADD, 64'h9, 64'h11, 1'b1, 64'h19, 1'b1, KIND_INTEGER},
    '{MODE_ADD, 64'h7fff_ffff_ffff_fff9, 64'h9, 1'b1, 64'h0, 1'b0, KIND_INTEGER},
    '{MODE_SUB, 64'h8000_0000_0000_0001, 64'h9, 1'b1, 64'h0, 1'b0, KIND_INTEGER},
    '{MODE_MUL, 64'h2_0000_0001, 64'h2_0000_0001, 1'b1, 64'h0, 1'b0, KIND_INTEGER},
    '{MODE_MUL, 64'hffff_fffe_0000_0001, 64'h2_0000_0001, 1'b0, 64'h0, 1'b0,
      KIND_INVALID},
    '{MODE_MUL, 64'h9, 64'h20a, 1'b1, 64'h0, 1'b0, KIND_INTEGER},
    '{MODE_NEG, 64'h8000_0000_0000_0001, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INTEGER},
    '{MODE_NEG, 64'h7fff_ffff_ffff_fff9, 64'h0, 1'b0, 64'h0, 1'b0, KIND_INVALID},
    // classification: zero word, object, char bounds, surrogates, specials
    '{MODE_CLASSIFY, 64'h0, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_CLASSIFY, 64'h1000, 64'h0, 1'b1, 64'h0, 1'b1, KIND_OBJECT},
    '{MODE_CLASSIFY, 64'h87fffa, 64'h0, 1'b1, 64'h0, 1'b1, KIND_CHAR},
    '{MODE_CLASSIFY, 64'h880002, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_CLASSIFY, 64'h6c002, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_CLASSIFY, 64'h6bffa, 64'h0, 1'b1, 64'h0, 1'b1, KIND_CHAR},
    '{MODE_CLASSIFY, 64'h3, 64'h0, 1'b1, 64'h0, 1'b1, KIND_NIL},
    '{MODE_CLASSIFY, 64'hb, 64'h0, 1'b1, 64'h0, 1'b1, KIND_FALSE},
    '{MODE_CLASSIFY, 64'h13, 64'h0, 1'b1, 64'h0, 1'b1, KIND_TRUE},
    '{MODE_CLASSIFY, 64'h1b, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_CLASSIFY, 64'hffff_ffff_ffff_ffff, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    // box range edges; kind still reports the raw lhs pattern
    '{MODE_BOX, 64'h0fff_ffff_ffff_ffff, 64'h0, 1'b0, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_BOX, 64'h1000_0000_0000_0000, 64'h0, 1'b1, 64'h0, 1'b0, KIND_OBJECT},
    '{MODE_BOX, 64'hefff_ffff_ffff_ffff, 64'h0, 1'b1, 64'h0, 1'b0, KIND_INVALID},
    '{MODE_BOX, 64'hf000_0000_0000_0000, 64'h0, 1'b0, 64'h0, 1'b0, KIND_INVALID},
    // unbox and the unused mode
    '{MODE_UNBOX, 64'hffff_ffff_ffff_fff9, 64'h0, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1,
      KIND_INTEGER},
    '{MODE_UNBOX, 64'h3, 64'h0, 1'b1, 64'h0, 1'b0, KIND_NIL},
    '{MODE_NOP, 64'h9, 64'h11, 1'b1, 64'h0, 1'b0, KIND_INTEGER}
  };

  // every register sees tags 1 and 7; one phase has all three
  // tags equal (int wins), one has the special tag at zero (never matches)
  phase_t phases [6] = '{
    '{3'd1, 3'd2, 3'd3,  0,  0,   0},
    '{3'd7, 3'd1, 3'd4, 54,  0,   0},
    '{3'd4, 3'd7, 3'd1,  0, 54,   0},
    '{3'd5, 3'd5, 3'd5, 17, 17,   0},
    '{3'd1, 3'd7, 3'd0,  0,  0, 300},
    '{3'd6, 3'd3, 3'd7, 17, 17,   0}
  };

  tagged_small_integer_alu dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // First match wins: object (tag 0), int, char, special.
  function automatic kind_t kind_of(input logic [63:0] w);
    logic [2:0]  tag;
    logic [60:0] pay;
    tag = w[2:0];
    pay = w[63:3];
    if (tag == 3'd0) return (w == 64'd0) ? KIND_INVALID : KIND_OBJECT;
    if (tag == int_tag_q) return KIND_INTEGER;
    if (tag == char_tag_q) begin
      if (pay <= CHAR_MAX && !(pay >= SURROGATE_LO && pay <= SURROGATE_HI))
        return KIND_CHAR;
      return KIND_INVALID;
    end
    if (tag == special_tag_q) begin
      if (pay == PAY_NIL) return KIND_NIL;
      if (pay == PAY_FALSE) return KIND_FALSE;
      if (pay == PAY_TRUE) return KIND_TRUE;
    end
    return KIND_INVALID;
  endfunction

  // Arithmetic runs at 128 bits so nothing wraps; a result is a small
  // integer when bits 127..60 are all copies of the sign.
  function automatic alu_out_t alu_predict(input mode_t op, input logic [63:0] lhs,
                                           input logic [63:0] rhs);
    alu_out_t           o;
    logic signed [60:0] pa;
    logic signed [60:0] pb;
    logic signed [63:0] raw;
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] r;
    bit                 arith;
    o = '0;
    o.kind = kind_of(lhs);
    pa = lhs[63:3];
    pb = rhs[63:3];
    raw = lhs;
    a = 128'(pa);
    b = 128'(pb);
    r = '0;
    arith = 1'b0;
    case (op) inside
      MODE_ADD, MODE_SUB, MODE_MUL: begin
        if (o.kind == KIND_INTEGER && kind_of(rhs) == KIND_INTEGER) begin
          arith = 1'b1;
          if (op == MODE_ADD) r = a + b;
          else if (op == MODE_SUB) r = a - b;
          else r = a * b;
        end
      end
      MODE_NEG: begin
        if (o.kind == KIND_INTEGER) begin
          arith = 1'b1;
          r = -a;
        end
      end
      MODE_CLASSIFY: o.ok = (o.kind != KIND_INVALID);
      MODE_BOX: begin
        arith = 1'b1;
        r = 128'(raw);
      end
      MODE_UNBOX: begin
        if (o.kind == KIND_INTEGER) begin
          o.ok = 1'b1;
          o.value = {{3{lhs[63]}}, lhs[63:3]};
        end
      end
      default: ;
    endcase
    if (arith && r[127:60] == {68{r[60]}}) begin
      o.ok = 1'b1;
      o.value = {r[60:0], int_tag_q};
    end
    return o;
  endfunction

  // ------------------------------------------------------------- stimulus

  // Small integer under the current int tag: small values, values at the
  // range edges, multiply-sized values that straddle overflow, anything.
  function automatic logic [63:0] rand_int_word();
    int                 pick;
    int                 sv;
    logic signed [60:0] p;
    logic [63:0]        full;
    pick = $urandom_range(99);
    full = {$urandom, $urandom};
    if (pick < 35) begin
      sv = $urandom_range(200);
      p = 61'(sv - 100);
    end else if (pick < 55) begin
      if ($urandom_range(1)) p = POS_MAX - 61'($urandom_range(3));
      else p = PAY_SIGN + 61'($urandom_range(3));
    end else if (pick < 85) begin
      p = 61'(full[30:0] >> $urandom_range(3));
      if ($urandom_range(1)) p = -p;
    end else begin
      p = full[60:0];
    end
    return {p, int_tag_q};
  endfunction

  // Any tagged operand, weighted toward small integers.
  function automatic logic [63:0] rand_operand();
    int          pick;
    logic [60:0] pay;
    logic [63:0] full;
    pick = $urandom_range(99);
    full = {$urandom, $urandom};
    if (pick < 70) return rand_int_word();
    if (pick < 78) begin
      case ($urandom_range(5))
        0: pay = 61'($urandom_range(32'hd7ff));
        1: pay = 61'($urandom_range(32'hdfff, 32'hd800));
        2: pay = CHAR_MAX;
        3: pay = CHAR_MAX + 61'($urandom_range(1, 3));
        4: pay = 61'($urandom_range(32'h10ffff, 32'he000));
        default: pay = full[60:0];
      endcase
      return {pay, char_tag_q};
    end
    if (pick < 85) begin
      pay = ($urandom_range(4) == 0) ? full[60:0] : 61'($urandom_range(3));
      return {pay, special_tag_q};
    end
    if (pick < 92) return ($urandom_range(3) == 0) ? 64'd0 : {full[63:3], 3'd0};
    return full;
  endfunction

  // Raw int64 for box: in range, near either edge, small, or anything.
  function automatic logic [63:0] rand_raw_int();
    int          sv;
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return {{3{full[60]}}, full[60:0]};
      1: begin
        sv = $urandom_range(4);
        if ($urandom_range(1)) return 64'h0fff_ffff_ffff_fffd + 64'(sv);
        return 64'hefff_ffff_ffff_fffe + 64'(sv);
      end
      2: begin
        sv = $urandom_range(200);
        sv = sv - 100;
        return 64'(sv);
      end
      default: return full;
    endcase
  endfunction

  // Offer one request, with a random gap first; the prediction is queued
  // at the edge where the request is taken.
  task automatic send_req(input mode_t op, input logic [63:0] lhs,
                          input logic [63:0] rhs, input alu_out_t want);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, rhs, lhs, op};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(want);
  endtask

  // Stop offering, let every result out, then let the pipe settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back writes of all three tags; the unused index is hit too and
  // must not disturb anything.
  task automatic program_tags(input logic [2:0] it, input logic [2:0] ct,
                              input logic [2:0] st);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INT_TAG;
    cfg_data  <= it;
    @(posedge clk);
    cfg_index <= CFG_CHAR_TAG;
    cfg_data  <= ct;
    @(posedge clk);
    cfg_index <= CFG_SPECIAL_TAG;
    cfg_data  <= st;
    @(posedge clk);
    cfg_index <= CFG_UNUSED_IDX;
    cfg_data  <= 3'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    int_tag_q     = it;
    char_tag_q    = ct;
    special_tag_q = st;
  endtask

  // Receiver: random stalls, plus a long hold-off on request so the pipe
  // backs up into s_tready.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------- checker

  always @(posedge clk) begin
    alu_out_t got;
    alu_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = alu_out_t'(m_tdata[67:0]);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result %h with no request pending", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          error_count++;
          $display("%0t: result value expected %h got %h", $time, want.value, got.value);
        end
        if (got.ok !== want.ok) begin
          error_count++;
          $display("%0t: ok expected %b got %b", $time, want.ok, got.ok);
        end
        if (got.kind !== want.kind) begin
          error_count++;
          $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------ main flow

  initial begin
    alu_out_t want;
    mode_t    op;
    logic [63:0] lhs;
    logic [63:0] rhs;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part runs on the reset tags, so it also proves them.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fixed) begin
        want.value = dir_rows[i].want_value;
        want.ok    = dir_rows[i].want_ok;
        want.kind  = dir_rows[i].want_kind;
      end else begin
        want = alu_predict(dir_rows[i].op, dir_rows[i].lhs, dir_rows[i].rhs);
      end
      send_req(dir_rows[i].op, dir_rows[i].lhs, dir_rows[i].rhs, want);
    end

    foreach (phases[p]) begin
      wait_drained();
      program_tags(phases[p].int_tag, phases[p].char_tag, phases[p].special_tag);
      idle_pct  = phases[p].idle;
      stall_pct = phases[p].stall;
      hold_req  = phases[p].hold;
      repeat (PHASE_REQS) begin
        op  = mode_t'($urandom_range(7));
        lhs = (op == MODE_BOX && $urandom_range(3) != 0) ? rand_raw_int() : rand_operand();
        rhs = rand_operand();
        send_req(op, lhs, rhs, alu_predict(op, lhs, rhs));
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* tagged_small_integer_alu.f */
src/tsia_pkg.sv
src/tagged_small_integer_alu.sv
tb/testbench.sv
